@@ rtl/core/half_duplex_uart_buffer_control_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Half-duplex UART buffer control: assertion macros
// Concurrent checks on the rising edge of clk; compiled out when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef HALF_DUPLEX_UART_BUFFER_CONTROL_UNIT_MACROS_SVH
`define HALF_DUPLEX_UART_BUFFER_CONTROL_UNIT_MACROS_SVH

`ifndef SYNTH
// checked outside reset
`define HDUART_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hduart check failed");
// checked on every edge, reset included
`define HDUART_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hduart check failed");
`else
`define HDUART_ASSERT(label, prop)
`define HDUART_ASSERT_ALWAYS(label, prop)
`endif

`endif

@@ rtl/core/hduart_pkg.sv @@
// ----------------------------------------------------------------------------
// hduart_pkg
// Command codes and the structs shared by the controller, the ring and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package hduart_pkg;

  localparam int unsigned CmdWidth  = 3;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CmdWidth-1:0] CMD_HOST_WRITE = 3'd0;
  localparam logic [CmdWidth-1:0] CMD_HOST_READ  = 3'd1;
  localparam logic [CmdWidth-1:0] CMD_LINE_RX    = 3'd2;
  localparam logic [CmdWidth-1:0] CMD_TX_READY   = 3'd3;
  localparam logic [CmdWidth-1:0] CMD_TX_DONE    = 3'd4;

  // operation applied to a ring (and to every cell of it)
  typedef struct packed {
    logic push;
    logic pop;
  } ring_op_t;

  // what a cell hands to its neighbor
  typedef struct packed {
    logic                 occ;
    logic [ByteWidth-1:0] value;
  } link_t;

  // ring status seen by the controller
  typedef struct packed {
    logic                 full;
    logic                 empty;
    logic [ByteWidth-1:0] head_value;
  } ring_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/hduart_if.sv @@
// ----------------------------------------------------------------------------
// hduart_if
// Valid/ready channels: command items in, result items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hduart_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data;

  modport source (output valid, output cmd, output data, input ready);
  modport sink (input valid, input cmd, input data, output ready);
endinterface

interface hduart_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_valid;
  logic       accepted;
  logic       drive_enable;

  modport source (output valid, output out_byte, output out_valid, output accepted,
                  output drive_enable, input ready);
  modport sink (input valid, input out_byte, input out_valid, input accepted,
                input drive_enable, output ready);
endinterface

`default_nettype wire

@@ rtl/core/hduart_cell.sv @@
// ----------------------------------------------------------------------------
// hduart_cell
// One slot of a shifting FIFO: loads on push at the fill boundary, takes the
// upper neighbor's contents on pop.
// ----------------------------------------------------------------------------
`default_nettype none

module hduart_cell
  import hduart_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ring_op_t             op,
  input  wire logic [ByteWidth-1:0] push_data,
  input  wire logic                 lower_occ,
  input  wire link_t                upper,
  output link_t                     state
);

  logic                 occ;
  logic [ByteWidth-1:0] value;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (op.pop) begin
      occ <= upper.occ;
    end else if (op.push && !occ && lower_occ) begin
      occ <= 1'b1;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (op.pop) begin
      value <= upper.value;
    end else if (op.push && !occ && lower_occ) begin
      value <= push_data;
    end
  end

  assign state = '{occ: occ, value: value};

endmodule

`default_nettype wire

@@ rtl/core/hduart_ring.sv @@
// ----------------------------------------------------------------------------
// hduart_ring
// Byte FIFO built as a row of cells; the oldest byte sits in cell 0.
// ----------------------------------------------------------------------------
`default_nettype none
`include "half_duplex_uart_buffer_control_unit_macros.svh"

module hduart_ring
  import hduart_pkg::*;
#(
  parameter int unsigned Depth = 31
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ring_op_t             op,
  input  wire logic [ByteWidth-1:0] push_data,
  output ring_stat_t                stat
);

  link_t             cells [Depth];
  logic [Depth-1:0]  occ;
  logic [Depth-1:0]  lower_occ;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    link_t upper;

    assign occ[i] = cells[i].occ;

    if (i == 0) begin : g_first
      assign lower_occ[i] = 1'b1;
    end else begin : g_rest
      assign lower_occ[i] = cells[i-1].occ;
    end

    if (i == Depth - 1) begin : g_last
      assign upper = '{occ: 1'b0, value: '0};
    end else begin : g_mid
      assign upper = cells[i+1];
    end

    hduart_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .push_data (push_data),
      .lower_occ (lower_occ[i]),
      .upper     (upper),
      .state     (cells[i])
    );
  end

  assign stat = '{full: occ[Depth-1], empty: !occ[0], head_value: cells[0].value};

  // occupied cells form one run starting at cell 0
  `HDUART_ASSERT(a_ring_contiguous, (occ & ~lower_occ) == '0)
  `HDUART_ASSERT(a_ring_no_underflow, op.pop |-> !stat.empty)
  `HDUART_ASSERT(a_ring_push_grows,
    op.push && !op.pop && !stat.full |=> $countones(occ) == $countones($past(occ)) + 1)

endmodule

`default_nettype wire

@@ rtl/core/half_duplex_uart_buffer_control_unit.sv @@
// ----------------------------------------------------------------------------
// half_duplex_uart_buffer_control_unit
// Transmit and receive byte rings plus the drive-direction flag of a
// half-duplex (RS-485 style) serial line.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one event item: cmd and data. cmd selects host
//   write, host read, line byte received, transmitter ready or transmit done.
//   rsp (valid/ready) returns exactly one result item per event: out_byte,
//   out_valid, accepted and drive_enable (direction after the event).
//   The result is registered and shows in the cycle after acceptance.
//   Throughput: one item per cycle while the result is taken; every event
//   touches at most one ring (a push at the fill boundary or a one-slot shift of the cells).
//   Each ring holds RING_SLOTS-1 bytes in a row of cells; pops shift the
//   whole row toward cell 0, so the oldest byte is always read from cell 0.
//   Reset (rst, synchronous) empties both rings, selects receive mode and
//   drops any pending result. No clearing pass is needed.
//   A stalled receiver holds the result register; req.ready then stays low
//   until the result is taken, so no result is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "half_duplex_uart_buffer_control_unit_macros.svh"

module half_duplex_uart_buffer_control_unit
  import hduart_pkg::*;
#(
  parameter int unsigned RING_SLOTS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  hduart_req_if.sink  req,
  hduart_rsp_if.source rsp
);

  // usable slots: each ring is built as a row of RING_SLOTS-1 cells, one byte per cell
  localparam int unsigned Depth = RING_SLOTS - 1;

  logic       accept;
  ring_op_t   tx_op;
  ring_op_t   rx_op;
  ring_stat_t tx_stat;
  ring_stat_t rx_stat;

  logic                 sending_mode;
  logic                 sending_mode_next;
  logic                 result_valid;
  logic [ByteWidth-1:0] result_byte;
  logic                 result_out_valid;
  logic                 result_accepted;
  logic                 result_drive;

  logic [ByteWidth-1:0] byte_next;
  logic                 out_valid_next;
  logic                 accepted_next;

  // a new item enters whenever the result register is free or being drained
  assign req.ready = !result_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // event decode; ring pushes and pops are gated on full/empty here
  always_comb begin
    tx_op             = '{push: 1'b0, pop: 1'b0};
    rx_op             = '{push: 1'b0, pop: 1'b0};
    sending_mode_next = sending_mode;
    byte_next         = '0;
    out_valid_next    = 1'b0;
    accepted_next     = 1'b0;
    if (accept) begin
      unique case (req.cmd)
        CMD_HOST_WRITE: begin
          tx_op.push    = !tx_stat.full;
          accepted_next = !tx_stat.full;
        end
        CMD_HOST_READ: begin
          if (!rx_stat.empty) begin
            rx_op.pop      = 1'b1;
            out_valid_next = 1'b1;
            byte_next      = rx_stat.head_value;
          end
        end
        CMD_LINE_RX: begin
          // while driving, the line byte is our own echo
          if (!sending_mode && !rx_stat.full) begin
            rx_op.push    = 1'b1;
            accepted_next = 1'b1;
          end
        end
        CMD_TX_READY: begin
          if (!tx_stat.empty) begin
            tx_op.pop         = 1'b1;
            out_valid_next    = 1'b1;
            byte_next         = tx_stat.head_value;
            sending_mode_next = 1'b1;
          end
        end
        CMD_TX_DONE: begin
          // release the line only once nothing is queued
          if (tx_stat.empty) begin
            sending_mode_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  hduart_ring #(
    .Depth (Depth)
  ) u_tx_ring (
    .clk       (clk),
    .rst       (rst),
    .op        (tx_op),
    .push_data (req.data),
    .stat      (tx_stat)
  );

  hduart_ring #(
    .Depth (Depth)
  ) u_rx_ring (
    .clk       (clk),
    .rst       (rst),
    .op        (rx_op),
    .push_data (req.data),
    .stat      (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sending_mode <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      sending_mode <= sending_mode_next;
      if (accept) begin
        result_valid <= 1'b1;
      end else if (rsp.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      result_byte      <= byte_next;
      result_out_valid <= out_valid_next;
      result_accepted  <= accepted_next;
      result_drive     <= sending_mode_next;
    end
  end

  assign rsp.valid        = result_valid;
  assign rsp.out_byte     = result_byte;
  assign rsp.out_valid    = result_out_valid;
  assign rsp.accepted     = result_accepted;
  assign rsp.drive_enable = result_drive;

  // a result never both carries a byte and reports a store
  `HDUART_ASSERT(a_result_exclusive, result_valid |-> !(result_out_valid && result_accepted))
  `HDUART_ASSERT(a_result_zero_byte,
    result_valid && !result_out_valid |-> result_byte == '0)
  // drive mode is entered only by sending a queued byte
  `HDUART_ASSERT(a_drive_on_send,
    $rose(sending_mode) |-> $past(accept && req.cmd == CMD_TX_READY && !tx_stat.empty))

endmodule

`default_nettype wire
